FILE: hdl/ds_twr_time_of_flight_core_assert.svh
// assertion macros used by the result stage (dtwr_out) of the ranging core
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef DS_TWR_TIME_OF_FLIGHT_CORE_ASSERT_SVH
`define DS_TWR_TIME_OF_FLIGHT_CORE_ASSERT_SVH

// condition holds at every edge outside reset
`define DTWR_ASSERT_NOW(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// same-cycle implication
`define DTWR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DTWR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/dtwr_pkg.sv
// shared types and constants of the ranging time-of-flight core
// no dependencies
package dtwr_pkg;

    localparam int STAMP_IN_BITS = 32;
    localparam int FLIGHT_BITS   = 33;

    // saturation bounds of the signed result, one bit wider than the field
    localparam logic [FLIGHT_BITS:0] FLIGHT_POS_LIMIT = 34'h0_FFFF_FFFF;
    localparam logic [FLIGHT_BITS:0] FLIGHT_NEG_LIMIT = 34'h1_0000_0000;

    typedef logic [STAMP_IN_BITS-1:0]      stamp_t;
    typedef logic signed [FLIGHT_BITS-1:0] flight_t;

    typedef struct packed {
        logic vld;
        logic neg;
        logic zero;
    } dtwr_flags_t;

endpackage

FILE: hdl/dtwr_stamps_if.sv
// input channel: the six timestamps of one ranging exchange
// depends on dtwr_pkg
interface dtwr_stamps_if import dtwr_pkg::*; ();
    logic   valid;
    logic   ready;
    stamp_t remote_poll_sent;
    stamp_t remote_resp_received;
    stamp_t remote_final_sent;
    stamp_t local_poll_received;
    stamp_t local_resp_sent;
    stamp_t local_final_received;

    modport source (
        output valid, remote_poll_sent, remote_resp_received, remote_final_sent,
               local_poll_received, local_resp_sent, local_final_received,
        input  ready
    );
    modport sink (
        input  valid, remote_poll_sent, remote_resp_received, remote_final_sent,
               local_poll_received, local_resp_sent, local_final_received,
        output ready
    );
endinterface

FILE: hdl/dtwr_flight_if.sv
// output channel: time of flight and zero-span flag
// depends on dtwr_pkg
interface dtwr_flight_if import dtwr_pkg::*; ();
    logic    valid;
    logic    ready;
    flight_t flight_ticks;
    logic    zero_span;

    modport source (output valid, flight_ticks, zero_span, input ready);
    modport sink   (input valid, flight_ticks, zero_span, output ready);
endinterface

FILE: hdl/dtwr_front.sv
// front pipeline: intervals, split products, denominator, signed magnitude
// depends on dtwr_pkg
module dtwr_front import dtwr_pkg::*; #(
    parameter int STAMP_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_vld,
    input  stamp_t                  remote_poll_sent,
    input  stamp_t                  remote_resp_received,
    input  stamp_t                  remote_final_sent,
    input  stamp_t                  local_poll_received,
    input  stamp_t                  local_resp_sent,
    input  stamp_t                  local_final_received,
    output dtwr_flags_t             out_flags,
    output logic [2*STAMP_BITS-1:0] out_mag,
    output logic [STAMP_BITS+1:0]   out_den
);

    localparam int W   = STAMP_BITS;
    localparam int H   = (W + 1) / 2;
    localparam int G   = W - H;
    localparam int D   = W + 2;
    localparam int P   = 2 * W;
    localparam int EXT = STAMP_IN_BITS + W;

    function automatic logic [W-1:0] low_bits(input stamp_t s);
        logic [EXT-1:0] e;
        e = EXT'(s);
        return e[W-1:0];
    endfunction

    // stage 1: wrapping intervals
    logic          s1_vld_reg;
    logic [W-1:0]  ra_reg, rb_reg, da_reg, db_reg;
    logic [W-1:0]  ra_next, rb_next, da_next, db_next;

    assign ra_next = low_bits(remote_resp_received) - low_bits(remote_poll_sent);
    assign rb_next = low_bits(local_final_received) - low_bits(local_resp_sent);
    assign da_next = low_bits(remote_final_sent) - low_bits(remote_resp_received);
    assign db_next = low_bits(local_resp_sent) - low_bits(local_poll_received);

    // stage 2: partial products and denominator
    logic          s2_vld_reg, s2_zero_reg;
    logic [D-1:0]  s2_den_reg, s2_den_next;
    logic [2*H-1:0] ll1_reg, ll2_reg, ll1_next, ll2_next;
    logic [H+G-1:0] lh1_reg, hl1_reg, lh2_reg, hl2_reg;
    logic [H+G-1:0] lh1_next, hl1_next, lh2_next, hl2_next;
    logic [2*G-1:0] hh1_reg, hh2_reg, hh1_next, hh2_next;

    assign s2_den_next = D'(ra_reg) + D'(rb_reg) + D'(da_reg) + D'(db_reg);

    assign ll1_next = (2*H)'(ra_reg[H-1:0]) * (2*H)'(rb_reg[H-1:0]);
    assign lh1_next = (H+G)'(ra_reg[H-1:0]) * (H+G)'(rb_reg[W-1:H]);
    assign hl1_next = (H+G)'(ra_reg[W-1:H]) * (H+G)'(rb_reg[H-1:0]);
    assign hh1_next = (2*G)'(ra_reg[W-1:H]) * (2*G)'(rb_reg[W-1:H]);
    assign ll2_next = (2*H)'(da_reg[H-1:0]) * (2*H)'(db_reg[H-1:0]);
    assign lh2_next = (H+G)'(da_reg[H-1:0]) * (H+G)'(db_reg[W-1:H]);
    assign hl2_next = (H+G)'(da_reg[W-1:H]) * (H+G)'(db_reg[H-1:0]);
    assign hh2_next = (2*G)'(da_reg[W-1:H]) * (2*G)'(db_reg[W-1:H]);

    // stage 3: full products
    logic          s3_vld_reg, s3_zero_reg;
    logic [D-1:0]  s3_den_reg;
    logic [P-1:0]  p1_reg, p2_reg, p1_next, p2_next;
    logic [W:0]    mid1, mid2;

    assign mid1    = (W+1)'(lh1_reg) + (W+1)'(hl1_reg);
    assign mid2    = (W+1)'(lh2_reg) + (W+1)'(hl2_reg);
    assign p1_next = {hh1_reg, ll1_reg} + P'({mid1, {H{1'b0}}});
    assign p2_next = {hh2_reg, ll2_reg} + P'({mid2, {H{1'b0}}});

    // stage 4: sign and magnitude of the numerator
    dtwr_flags_t   s4_flags_reg;
    logic [D-1:0]  s4_den_reg;
    logic [P-1:0]  s4_mag_reg, s4_mag_next;
    logic          s4_neg_next;

    assign s4_neg_next = p1_reg < p2_reg;
    assign s4_mag_next = s4_neg_next ? (p2_reg - p1_reg) : (p1_reg - p2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s3_vld_reg   <= 1'b0;
            s4_flags_reg <= '0;
        end
        else if (en)
        begin
            s1_vld_reg        <= in_vld;
            s2_vld_reg        <= s1_vld_reg;
            s3_vld_reg        <= s2_vld_reg;
            s4_flags_reg.vld  <= s3_vld_reg;
            s4_flags_reg.neg  <= s4_neg_next;
            s4_flags_reg.zero <= s3_zero_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ra_reg      <= ra_next;
            rb_reg      <= rb_next;
            da_reg      <= da_next;
            db_reg      <= db_next;
            s2_den_reg  <= s2_den_next;
            s2_zero_reg <= ~|{ra_reg, rb_reg, da_reg, db_reg};
            ll1_reg     <= ll1_next;
            lh1_reg     <= lh1_next;
            hl1_reg     <= hl1_next;
            hh1_reg     <= hh1_next;
            ll2_reg     <= ll2_next;
            lh2_reg     <= lh2_next;
            hl2_reg     <= hl2_next;
            hh2_reg     <= hh2_next;
            s3_den_reg  <= s2_den_reg;
            s3_zero_reg <= s2_zero_reg;
            p1_reg      <= p1_next;
            p2_reg      <= p2_next;
            s4_den_reg  <= s3_den_reg;
            s4_mag_reg  <= s4_mag_next;
        end
    end

    assign out_flags = s4_flags_reg;
    assign out_mag   = s4_mag_reg;
    assign out_den   = s4_den_reg;

endmodule

FILE: hdl/dtwr_div_cell.sv
// one restoring-division cell: resolves one quotient bit per item
// depends on dtwr_pkg
module dtwr_div_cell import dtwr_pkg::*; #(
    parameter int STAMP_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  dtwr_flags_t             in_flags,
    input  logic [STAMP_BITS+1:0]   in_rem,
    input  logic [2*STAMP_BITS-1:0] in_nq,
    input  logic [STAMP_BITS+1:0]   in_den,
    output dtwr_flags_t             out_flags,
    output logic [STAMP_BITS+1:0]   out_rem,
    output logic [2*STAMP_BITS-1:0] out_nq,
    output logic [STAMP_BITS+1:0]   out_den
);

    localparam int D = STAMP_BITS + 2;
    localparam int P = 2 * STAMP_BITS;

    dtwr_flags_t  flags_reg;
    logic [D-1:0] rem_reg, den_reg, rem_next;
    logic [P-1:0] nq_reg, nq_next;
    logic [D:0]   trial, diff;
    logic         ge;

    // numerator bits leave at the top, quotient bits enter at the bottom
    assign trial    = {in_rem, in_nq[P-1]};
    assign diff     = trial - {1'b0, in_den};
    assign ge       = ~diff[D];
    assign rem_next = ge ? diff[D-1:0] : trial[D-1:0];
    assign nq_next  = {in_nq[P-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (en)
        begin
            flags_reg <= in_flags;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
            den_reg <= in_den;
        end
    end

    assign out_flags = flags_reg;
    assign out_rem   = rem_reg;
    assign out_nq    = nq_reg;
    assign out_den   = den_reg;

endmodule

FILE: hdl/dtwr_out.sv
// result stage: saturation, sign, output register and skid register
// depends on dtwr_pkg and the assertion macro header
`include "ds_twr_time_of_flight_core_assert.svh"

module dtwr_out import dtwr_pkg::*; #(
    parameter int STAMP_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dtwr_flags_t             p_flags,
    input  logic [2*STAMP_BITS-1:0] p_quot,
    output logic                    en,
    input  logic                    out_ready,
    output logic                    out_vld,
    output flight_t                 out_ticks,
    output logic                    out_zero
);

    localparam int P  = 2 * STAMP_BITS;
    localparam int QX = (P > FLIGHT_BITS + 1) ? P : FLIGHT_BITS + 1;

    logic [QX-1:0]          qx;
    logic                   big_pos, big_neg;
    logic [FLIGHT_BITS-1:0] mag;
    flight_t                ticks;

    assign qx      = QX'(p_quot);
    assign big_pos = qx > QX'(FLIGHT_POS_LIMIT);
    assign big_neg = qx > QX'(FLIGHT_NEG_LIMIT);

    always_comb
    begin
        if (p_flags.neg)
        begin
            mag = big_neg ? FLIGHT_NEG_LIMIT[FLIGHT_BITS-1:0] : qx[FLIGHT_BITS-1:0];
        end
        else
        begin
            mag = big_pos ? FLIGHT_POS_LIMIT[FLIGHT_BITS-1:0] : qx[FLIGHT_BITS-1:0];
        end
    end

    assign ticks = p_flags.zero ? '0 : (p_flags.neg ? flight_t'(-mag) : flight_t'(mag));

    logic    o_vld_reg, s_vld_reg;
    flight_t o_ticks_reg, s_ticks_reg;
    logic    o_zero_reg, s_zero_reg;
    logic    take, load_o, load_s, from_s;

    // pipeline moves only while the skid register is empty
    assign en   = ~s_vld_reg;
    assign take = o_vld_reg & out_ready;

    always_comb
    begin
        load_o = 1'b0;
        load_s = 1'b0;
        from_s = 1'b0;
        priority if (take)
        begin
            from_s = s_vld_reg;
            load_o = s_vld_reg | p_flags.vld;
        end
        else if (!o_vld_reg)
        begin
            load_o = p_flags.vld;
        end
        else
        begin
            load_s = p_flags.vld & en;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
        end
        else
        begin
            if (take || !o_vld_reg)
            begin
                o_vld_reg <= load_o;
            end
            if (from_s)
            begin
                s_vld_reg <= 1'b0;
            end
            else if (load_s)
            begin
                s_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_o)
        begin
            o_ticks_reg <= from_s ? s_ticks_reg : ticks;
            o_zero_reg  <= from_s ? s_zero_reg : p_flags.zero;
        end
        if (load_s)
        begin
            s_ticks_reg <= ticks;
            s_zero_reg  <= p_flags.zero;
        end
    end

    assign out_vld   = o_vld_reg;
    assign out_ticks = o_ticks_reg;
    assign out_zero  = o_zero_reg;

    `DTWR_ASSERT_IMPL(a_skid_behind_out, clk, rst_n,
        s_vld_reg, o_vld_reg, "skid full while output empty")
    `DTWR_ASSERT_NEXT(a_stall_to_skid, clk, rst_n,
        o_vld_reg && !out_ready && p_flags.vld && en, s_vld_reg, "result lost on stall")
    `DTWR_ASSERT_NEXT(a_skid_drain, clk, rst_n,
        take && s_vld_reg, o_vld_reg && !s_vld_reg, "skid not drained after transfer")
    `DTWR_ASSERT_IMPL(a_zero_forces_zero, clk, rst_n,
        o_vld_reg && o_zero_reg, o_ticks_reg == '0, "zero span with nonzero ticks")

endmodule

FILE: hdl/ds_twr_time_of_flight_core.sv
// top level of the double-sided two-way ranging time-of-flight core
// depends on dtwr_pkg, dtwr_stamps_if, dtwr_flight_if, dtwr_front, dtwr_div_cell, dtwr_out
//
// stamps (sink): six timestamps of one ranging exchange; only the low STAMP_BITS
// bits of each are used. flight (source): signed time of flight in device ticks,
// truncated toward zero and saturated to 33 bits, plus zero_span when all four
// intervals are zero (ticks then read zero).
// one exchange can be transferred in every cycle while stamps.ready is high.
// a result passes through four front stages (intervals, split products, product
// sums, sign and magnitude), then one division cell per quotient bit, then the
// output register. the division is a row of 2*STAMP_BITS cells, each resolving
// one quotient bit and passing remainder, numerator and divisor on to its neighbor
// in every cycle that the row is not held.
// when flight stalls, the output register holds its result and one more result
// lands in a skid register; stamps.ready then drops and the whole row holds.
// reset clears all valid bits; no clearing pass, the block is ready right after.
module ds_twr_time_of_flight_core import dtwr_pkg::*; #(
    parameter int STAMP_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    dtwr_stamps_if.sink          stamps,
    dtwr_flight_if.source        flight
);

    localparam int D = STAMP_BITS + 2;
    localparam int P = 2 * STAMP_BITS;

    logic         en;
    dtwr_flags_t  flag_tap [0:P];
    logic [D-1:0] rem_tap  [0:P];
    logic [P-1:0] nq_tap   [0:P];
    logic [D-1:0] den_tap  [0:P];

    assign stamps.ready = en;
    assign rem_tap[0]   = '0;

    dtwr_front #(.STAMP_BITS(STAMP_BITS)) u_front (
        .clk                  (clk),
        .rst_n                (rst_n),
        .en                   (en),
        .in_vld               (stamps.valid),
        .remote_poll_sent     (stamps.remote_poll_sent),
        .remote_resp_received (stamps.remote_resp_received),
        .remote_final_sent    (stamps.remote_final_sent),
        .local_poll_received  (stamps.local_poll_received),
        .local_resp_sent      (stamps.local_resp_sent),
        .local_final_received (stamps.local_final_received),
        .out_flags            (flag_tap[0]),
        .out_mag              (nq_tap[0]),
        .out_den              (den_tap[0])
    );

    for (genvar i = 0; i < P; i++)
    begin : g_cell
        dtwr_div_cell #(.STAMP_BITS(STAMP_BITS)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_flags  (flag_tap[i]),
            .in_rem    (rem_tap[i]),
            .in_nq     (nq_tap[i]),
            .in_den    (den_tap[i]),
            .out_flags (flag_tap[i+1]),
            .out_rem   (rem_tap[i+1]),
            .out_nq    (nq_tap[i+1]),
            .out_den   (den_tap[i+1])
        );
    end

    dtwr_out #(.STAMP_BITS(STAMP_BITS)) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .p_flags   (flag_tap[P]),
        .p_quot    (nq_tap[P]),
        .en        (en),
        .out_ready (flight.ready),
        .out_vld   (flight.valid),
        .out_ticks (flight.flight_ticks),
        .out_zero  (flight.zero_span)
    );

endmodule

FILE: test/tb_top.sv
// testbench for ds_twr_time_of_flight_core: drives ranging exchanges, checks each time of flight
// depends on dtwr_pkg, dtwr_stamps_if, dtwr_flight_if and the core itself
`timescale 1ns / 1ps

module tb_top;
    import dtwr_pkg::*;

    localparam int STAMP_BITS       = 32;
    localparam int WIDE             = 2 * STAMP_BITS;
    localparam int LATENCY          = 2 * STAMP_BITS + 4;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_EXCHANGES = 1500;
    localparam int HOLD_CYCLES      = 400;

    typedef struct packed {
        stamp_t remote_poll_sent;
        stamp_t remote_resp_received;
        stamp_t remote_final_sent;
        stamp_t local_poll_received;
        stamp_t local_resp_sent;
        stamp_t local_final_received;
    } exchange_t;

    typedef struct packed {
        flight_t ticks;
        logic    zero;
    } flight_result_t;

    typedef enum {RX_FREE, RX_COIN, RX_PATTERN, RX_STARVED} rx_mode_t;
    typedef enum {EX_RANGING, EX_SPANS, EX_RAW, EX_ZERO} exchange_kind_t;

    class flight_scoreboard;
        flight_result_t expected_flights[$];
        int             mismatches;

        function flight_result_t time_of_flight(exchange_t x);
            logic [STAMP_BITS-1:0] ra, rb, da, db;
            logic [STAMP_BITS+1:0] span_sum;
            logic [WIDE-1:0]       fwd, back, mag, quo;
            logic [FLIGHT_BITS:0]  sat;
            logic                  neg;
            flight_result_t        r;
            ra = x.remote_resp_received - x.remote_poll_sent;
            rb = x.local_final_received - x.local_resp_sent;
            da = x.remote_final_sent - x.remote_resp_received;
            db = x.local_resp_sent - x.local_poll_received;
            span_sum = ra + rb + da + db;
            r.ticks = '0;
            r.zero  = 1'b0;
            if (span_sum == 0)
            begin
                r.zero = 1'b1;
                return r;
            end
            fwd  = WIDE'(ra) * WIDE'(rb);
            back = WIDE'(da) * WIDE'(db);
            neg  = fwd < back;
            mag  = neg ? back - fwd : fwd - back;
            // dividing the magnitude truncates toward zero for either sign
            quo  = mag / WIDE'(span_sum);
            if (neg)
            begin
                sat = (quo > WIDE'(FLIGHT_NEG_LIMIT)) ? FLIGHT_NEG_LIMIT : quo[FLIGHT_BITS:0];
                sat = -sat;
            end
            else
            begin
                sat = (quo > WIDE'(FLIGHT_POS_LIMIT)) ? FLIGHT_POS_LIMIT : quo[FLIGHT_BITS:0];
            end
            r.ticks = sat[FLIGHT_BITS-1:0];
            return r;
        endfunction

        function void note_exchange(exchange_t x);
            expected_flights.push_back(time_of_flight(x));
        endfunction

        function void check_flight(flight_t ticks, logic zero);
            flight_result_t want;
            if (expected_flights.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: ticks %0d zero_span %b", ticks, zero);
                return;
            end
            want = expected_flights.pop_front();
            if (ticks !== want.ticks || zero !== want.zero)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected ticks %0d zero_span %b, got ticks %0d zero_span %b",
                             want.ticks, want.zero, ticks, zero);
            end
        endfunction

        function int pending();
            return expected_flights.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   hold_request;
    int   burst_left;
    int   cycles;

    flight_scoreboard sb = new();

    dtwr_stamps_if stamps_ch ();
    dtwr_flight_if flight_ch ();

    ds_twr_time_of_flight_core #(
        .STAMP_BITS (STAMP_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stamps (stamps_ch),
        .flight (flight_ch)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // transfers on both channels are sampled before the edge's updates land
    always @(posedge clk)
    begin
        if (rst_n && stamps_ch.valid && stamps_ch.ready)
            sb.note_exchange('{stamps_ch.remote_poll_sent, stamps_ch.remote_resp_received,
                               stamps_ch.remote_final_sent, stamps_ch.local_poll_received,
                               stamps_ch.local_resp_sent, stamps_ch.local_final_received});
        if (rst_n && flight_ch.valid && flight_ch.ready)
            sb.check_flight(flight_ch.flight_ticks, flight_ch.zero_span);
    end

    // result side: modes of random length, plus long hold-offs on request
    initial
    begin
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        int       phase;
        mode      = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        phase     = 0;
        flight_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                flight_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_FREE:    flight_ch.ready <= 1'b1;
                    RX_COIN:    flight_ch.ready <= $urandom_range(0, 1);
                    RX_PATTERN: flight_ch.ready <= (phase % 5) != 0;
                    default:    flight_ch.ready <= $urandom_range(0, 3) == 0;
                endcase
            end
        end
    end

    function automatic exchange_t make_exchange(stamp_t remote_base, stamp_t ra, stamp_t da,
                                                stamp_t local_base, stamp_t db, stamp_t rb);
        exchange_t x;
        x.remote_poll_sent     = remote_base;
        x.remote_resp_received = x.remote_poll_sent + ra;
        x.remote_final_sent    = x.remote_resp_received + da;
        x.local_poll_received  = local_base;
        x.local_resp_sent      = x.local_poll_received + db;
        x.local_final_received = x.local_resp_sent + rb;
        return x;
    endfunction

    // interval of random magnitude, from zero up to the full stamp range
    function automatic stamp_t random_span();
        logic [STAMP_BITS:0] keep;
        keep = (33'd1 << $urandom_range(0, STAMP_BITS)) - 1;
        return stamp_t'($urandom) & keep[STAMP_BITS-1:0];
    endfunction

    function automatic exchange_t random_exchange();
        exchange_kind_t kind;
        int             pick;
        int             flight;
        stamp_t         da, db;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            kind = EX_RANGING;
        else if (pick < 85)
            kind = EX_SPANS;
        else if (pick < 95)
            kind = EX_RAW;
        else
            kind = EX_ZERO;
        case (kind)
            EX_RANGING:
            begin
                // round trips exceed the replies by twice the flight, plus clock noise
                flight = $urandom_range(0, 20000);
                da     = random_span();
                db     = random_span();
                return make_exchange($urandom, db + 2 * flight + $urandom_range(0, 6) - 3, da,
                                     $urandom, db, da + 2 * flight + $urandom_range(0, 6) - 3);
            end
            EX_SPANS:
                return make_exchange($urandom, random_span(), random_span(),
                                     $urandom, random_span(), random_span());
            EX_RAW:
                return '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            default:
                return make_exchange($urandom, '0, '0, $urandom, '0, '0);
        endcase
    endfunction

    task automatic send_exchange(exchange_t x);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                stamps_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        stamps_ch.valid                <= 1'b1;
        stamps_ch.remote_poll_sent     <= x.remote_poll_sent;
        stamps_ch.remote_resp_received <= x.remote_resp_received;
        stamps_ch.remote_final_sent    <= x.remote_final_sent;
        stamps_ch.local_poll_received  <= x.local_poll_received;
        stamps_ch.local_resp_sent      <= x.local_resp_sent;
        stamps_ch.local_final_received <= x.local_final_received;
        @(posedge clk);
        while (!stamps_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        stamps_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int i;
        rst_n                          <= 1'b0;
        stamps_ch.valid                <= 1'b0;
        stamps_ch.remote_poll_sent     <= '0;
        stamps_ch.remote_resp_received <= '0;
        stamps_ch.remote_final_sent    <= '0;
        stamps_ch.local_poll_received  <= '0;
        stamps_ch.local_resp_sent      <= '0;
        stamps_ch.local_final_received <= '0;
        burst_left   = 0;
        hold_request = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero spans at both ends of the stamp range and at mid-range bases
        send_exchange('{'0, '0, '0, '0, '0, '0});
        send_exchange('{'1, '1, '1, '1, '1, '1});
        send_exchange(make_exchange(32'h1234_5678, '0, '0, 32'h8765_4321, '0, '0));
        // all intervals at their maximum, pairs at the maximum, and one at the maximum against a unit interval
        send_exchange(make_exchange('0, '1, '1, '0, '1, '1));
        send_exchange(make_exchange('0, '1, '0, '0, '0, '1));
        send_exchange(make_exchange('0, '0, '1, '0, '1, '0));
        send_exchange(make_exchange('1, '1, '0, '1, '0, 32'd1));
        // a single interval nonzero
        send_exchange(make_exchange(32'd100, '0, 32'd5, 32'd7, '0, '0));
        send_exchange(make_exchange(32'd100, '0, '0, 32'd7, '0, 32'd9));
        // small quotients, truncation toward zero on both sides
        send_exchange(make_exchange('0, 32'd1, '0, '0, '0, 32'd1));
        send_exchange(make_exchange('0, 32'd2, '0, '0, '0, 32'd2));
        send_exchange(make_exchange('0, '0, 32'd3, '0, 32'd3, '0));
        send_exchange(make_exchange('0, '0, 32'd4, '0, 32'd4, '0));
        send_exchange(make_exchange('0, 32'd1, 32'd2, '0, 32'd2, 32'd1));
        // equal products give zero flight
        send_exchange(make_exchange(32'd50, 32'd6, 32'd3, 32'd60, 32'd8, 32'd4));
        // timestamps wrapping through zero
        send_exchange(make_exchange(32'hFFFF_F000, 32'd10400, 32'd8000,
                                    32'hFFFF_FF00, 32'd8200, 32'd10600));
        send_exchange('{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                        32'hFFFF_FFFE, 32'h0000_0003, 32'h7FFF_0000});
        send_exchange('{32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF,
                        32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000});
        // a plausible exchange
        send_exchange(make_exchange(32'h0010_0000, 32'd10300, 32'd8000,
                                    32'h2000_0000, 32'd9000, 32'd8300));
        wait_drained();

        for (i = 0; i < RANDOM_EXCHANGES; i++)
        begin
            if (i == 300 || i == 1100)
                hold_request = 1'b1;
            if (i == 800)
                wait_drained();
            send_exchange(random_exchange());
        end
        stamps_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        // catch any stray result trailing the last expected one
        repeat (LATENCY + 32) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: ds_twr_time_of_flight_core.f
+incdir+hdl
hdl/dtwr_pkg.sv
hdl/dtwr_stamps_if.sv
hdl/dtwr_flight_if.sv
hdl/dtwr_front.sv
hdl/dtwr_div_cell.sv
hdl/dtwr_out.sv
hdl/ds_twr_time_of_flight_core.sv
test/tb_top.sv
